@@ rtl/core/pol_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and widths for the positional ordered list.
package pol_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int WIDTH_DEF = 32;

  localparam int OP_W     = 3;
  localparam int POS_W    = 6;
  localparam int VALUE_W  = 32;
  localparam int ELEM_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_POS   = 3'd5,
    OP_READOUT   = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;      // latch the request payload
    logic exec;      // apply insert or delete, load the single result
    logic rd_clear;  // reset the readout index
    logic rd_step;   // load one readout result, advance the index
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
    logic run_read;  // request is a readout of a non-empty list
    logic rd_last;   // readout index sits on the last stored word
  } stat_t;

endpackage

@@ rtl/core/pol_if.sv @@
`timescale 1ns / 1ps
// Request and result channel interfaces for the positional ordered list.
interface pol_req_if;
  import pol_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [POS_W-1:0]   position;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output operation, output position, output value,
                  input ready);
  modport sink   (input valid, input operation, input position, input value,
                  output ready);
endinterface

interface pol_rsp_if;
  import pol_pkg::*;
  logic                valid;
  logic                ready;
  logic [ELEM_W-1:0]   element;
  logic                last_of_run;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  count;

  modport source (output valid, output element, output last_of_run, output status,
                  output count, input ready);
  modport sink   (input valid, input element, input last_of_run, input status,
                  input count, output ready);
endinterface

@@ rtl/core/positional_ordered_list.sv @@
`timescale 1ns / 1ps
// Top level of the positional ordered list: controller plus datapath.
//
// Usage:
//   req carries one request per transfer: operation, 1-based position and
//   value. rsp carries results: element, last_of_run, status and count.
//   Insert and delete requests, and any other request except a readout of a
//   non-empty list, give exactly one result with last_of_run set.
//   A readout of n stored words gives n results in list order, first word
//   first; last_of_run marks the final one.
// Timing:
//   A request is taken in S_IDLE and executed in S_EXEC once the output
//   register is free; a single result is loaded into that register. A
//   readout clears the index in S_EXEC, then walks the list in S_READ, one
//   word per cycle while the output register is free. No new request is
//   taken outside S_IDLE; inserts and deletes shift the affected slots at once.
// Reset:
//   rst empties the list, drops any pending result and holds req.ready low.
//   Stored words are not cleared; slots above the count are never read.
// Backpressure:
//   A result waits in the output register while rsp.ready is low; the next
//   request is still accepted and executes as soon as that register frees.
module positional_ordered_list #(
  parameter int DEPTH = pol_pkg::DEPTH_DEF,
  parameter int WIDTH = pol_pkg::WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  pol_req_if.sink   req,
  pol_rsp_if.source rsp
);
  import pol_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencing: take, execute, then walk the list for a readout.
  pol_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Slot store, length count, readout index and result register.
  pol_dp #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .operation (req.operation),
    .position  (req.position),
    .value     (req.value),
    .cmd       (cmd),
    .stat      (stat),
    .rsp       (rsp)
  );

endmodule

@@ rtl/core/pol_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine for the positional ordered list.
module pol_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  pol_pkg::stat_t stat,
  output pol_pkg::cmd_t  cmd
);
  import pol_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (stat.run_read) state_next = S_READ;
        else if (stat.out_free) state_next = S_IDLE;
      end
      S_READ: begin
        if (stat.out_free && stat.rd_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready    = 1'b0;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        req_ready = !rst;
        cmd.take  = req_valid && !rst;
      end
      S_EXEC: begin
        cmd.rd_clear = stat.run_read;
        cmd.exec     = !stat.run_read && stat.out_free;
      end
      S_READ: begin
        cmd.rd_step = stat.out_free;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/core/pol_dp.sv @@
`timescale 1ns / 1ps
// Datapath for the positional ordered list: shifting word store and result register.
module pol_dp #(
  parameter int DEPTH = pol_pkg::DEPTH_DEF,
  parameter int WIDTH = pol_pkg::WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [pol_pkg::OP_W-1:0]    operation,
  input  logic [pol_pkg::POS_W-1:0]   position,
  input  logic [pol_pkg::VALUE_W-1:0] value,
  input  pol_pkg::cmd_t               cmd,
  output pol_pkg::stat_t              stat,
  pol_rsp_if.source                   rsp
);
  import pol_pkg::*;

  localparam int LW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1;
  localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

  // Request registers
  op_t              op_q;
  logic [POS_W-1:0] pos_q;
  logic [WIDTH-1:0] val_q;

  // List state
  logic [WIDTH-1:0] entries [DEPTH];
  logic [LW-1:0]    length;
  logic [LW-1:0]    length_next;
  logic [IW-1:0]    read_idx;

  // Result register
  logic                out_valid;
  logic [ELEM_W-1:0]   out_element;
  logic                out_last;
  status_t             out_status;
  logic [COUNT_W-1:0]  out_count;

  // Decode
  logic          full;
  logic          empty;
  logic [CW-1:0] pos_c;
  logic [CW-1:0] len_c;
  logic          do_ins;
  logic          do_del;
  logic [LW-1:0] idx;
  status_t       st;

  assign full  = (length >= DEPTH_L);
  assign empty = (length == '0);
  assign pos_c = CW'(pos_q);
  assign len_c = CW'(length);

  always_comb begin
    do_ins = 1'b0;
    do_del = 1'b0;
    idx    = '0;
    st     = ST_OK;
    unique case (op_q)
      OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
        if (full) begin
          st = ST_FULL;
        end else if (op_q == OP_INS_FRONT) begin
          do_ins = 1'b1;
        end else if (op_q == OP_INS_BACK) begin
          do_ins = 1'b1;
          idx    = length;
        end else if (pos_c == '0 || pos_c > len_c + CW'(1)) begin
          st = ST_INVALID;
        end else begin
          do_ins = 1'b1;
          idx    = LW'(pos_c - CW'(1));
        end
      end
      OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
        if (empty) begin
          st = ST_EMPTY;
        end else if (op_q == OP_DEL_FRONT) begin
          do_del = 1'b1;
        end else if (op_q == OP_DEL_BACK) begin
          do_del = 1'b1;
          idx    = length - LW'(1);
        end else if (pos_c == '0 || pos_c > len_c) begin
          st = ST_INVALID;
        end else begin
          do_del = 1'b1;
          idx    = LW'(pos_c - CW'(1));
        end
      end
      OP_READOUT: begin
        if (empty) st = ST_EMPTY;
      end
      default: st = ST_INVALID;
    endcase
  end

  always_comb begin
    length_next = length;
    if (do_ins) length_next = length + LW'(1);
    else if (do_del) length_next = length - LW'(1);
  end

  assign stat.out_free = !out_valid || rsp.ready;
  assign stat.run_read = (op_q == OP_READOUT) && !empty;
  assign stat.rd_last  = (LW'(read_idx) + LW'(1) == length);

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_q  <= op_t'(operation);
      pos_q <= position;
      val_q <= WIDTH'(value);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
    end else if (cmd.exec) begin
      length <= length_next;
    end
  end

  // Slots at or above the position move one place up on insert, down on delete.
  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    localparam logic [LW-1:0] SLOT = LW'(i);
    always_ff @(posedge clk) begin
      if (cmd.exec && do_ins) begin
        if (SLOT == idx) begin
          entries[i] <= val_q;
        end else if (SLOT > idx) begin
          entries[i] <= entries[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd.exec && do_del) begin
        if (SLOT >= idx && i < DEPTH - 1) begin
          entries[i] <= entries[(i < DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_clear) begin
      read_idx <= '0;
    end else if (cmd.rd_step) begin
      read_idx <= read_idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec || cmd.rd_step) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_element <= '0;
      out_last    <= 1'b1;
      out_status  <= st;
      out_count   <= COUNT_W'(length_next);
    end else if (cmd.rd_step) begin
      out_element <= ELEM_W'(entries[read_idx]);
      out_last    <= stat.rd_last;
      out_status  <= ST_OK;
      out_count   <= COUNT_W'(length);
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.element     = out_element;
  assign rsp.last_of_run = out_last;
  assign rsp.status      = out_status;
  assign rsp.count       = out_count;

endmodule

@@ sim/positional_ordered_list_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the positional ordered list: directed and random requests.
module positional_ordered_list_tb;
  import pol_pkg::*;

  localparam int              LIST_DEPTH    = DEPTH_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED     = 3'd7;
  localparam int              RANDOM_ITEMS  = 430;
  localparam int              LONG_HOLD     = 300;
  localparam int              SETTLE_CYCLES = 64;
  localparam int              TIMEOUT_NS    = 1_000_000;

  // One result as it shows on the result channel.
  typedef struct {
    logic [ELEM_W-1:0]   element;
    logic                last_of_run;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } list_result_t;

  // Which way the random requests push the list length.
  typedef enum {DRIFT_GROW, DRIFT_SHRINK, DRIFT_MIX} drift_t;

  // How the result side applies backpressure during one segment.
  typedef enum {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_HOLD} rx_mode_t;

  // Keeps a copy of the stored words, derives the results that each accepted
  // request causes and compares them against what the block returns.
  class list_scoreboard;
    logic [VALUE_W-1:0] stored[$];
    list_result_t       awaited[$];
    int                 errors = 0;

    function int unsigned length();
      return stored.size();
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function void push_result(logic [ELEM_W-1:0] element, logic last_of_run,
                              logic [STATUS_W-1:0] status);
      list_result_t r;
      r.element     = element;
      r.last_of_run = last_of_run;
      r.status      = status;
      r.count       = COUNT_W'(stored.size());
      awaited.push_back(r);
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                               logic [VALUE_W-1:0] value);
      logic [STATUS_W-1:0] status;
      int unsigned         n;
      status = ST_OK;
      n      = stored.size();
      case (op)
        OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
          // A full list refuses every insert, whatever the position.
          if (n >= LIST_DEPTH) begin
            status = ST_FULL;
          end else if (op == OP_INS_FRONT) begin
            stored.push_front(value);
          end else if (op == OP_INS_BACK) begin
            stored.push_back(value);
          end else if (pos < 1 || pos > n + 1) begin
            status = ST_INVALID;
          end else begin
            stored.insert(pos - 1, value);
          end
        end
        OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
          if (n == 0) begin
            status = ST_EMPTY;
          end else if (op == OP_DEL_FRONT) begin
            void'(stored.pop_front());
          end else if (op == OP_DEL_BACK) begin
            void'(stored.pop_back());
          end else if (pos < 1 || pos > n) begin
            status = ST_INVALID;
          end else begin
            stored.delete(pos - 1);
          end
        end
        OP_READOUT: begin
          if (n == 0) begin
            status = ST_EMPTY;
          end else begin
            for (int i = 0; i < n; i++) begin
              push_result(stored[i], (i == n - 1), ST_OK);
            end
            return;
          end
        end
        default: status = ST_INVALID;
      endcase
      push_result('0, 1'b1, status);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    endtask

    task check_result(logic [ELEM_W-1:0] element, logic last_of_run,
                      logic [STATUS_W-1:0] status, logic [COUNT_W-1:0] count);
      list_result_t want;
      if (awaited.size() == 0) begin
        report_mismatch("unrequested result element", element, 0);
        return;
      end
      want = awaited.pop_front();
      if (element !== want.element) report_mismatch("element", element, want.element);
      if (last_of_run !== want.last_of_run)
        report_mismatch("last_of_run", last_of_run, want.last_of_run);
      if (status !== want.status) report_mismatch("status", status, want.status);
      if (count !== want.count) report_mismatch("count", count, want.count);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  pol_req_if req_ch ();
  pol_rsp_if rsp_ch ();

  positional_ordered_list u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  list_scoreboard sb = new();

  // Sender burst bookkeeping: transfers left in this burst, and whether
  // valid is currently held high.
  int unsigned burst_left = 0;
  bit          req_held   = 1'b0;

  always #1 clk = ~clk;

  // Hard stop in case the block hangs on either channel.
  initial begin
    #(TIMEOUT_NS);
    $display("positional_ordered_list regression: fail");
    $finish;
  end

  // Offer one request and hold it until the block takes it. Note the transfer
  // in the scoreboard at the same edge, then either keep the burst going or
  // drop valid for a random gap.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic [VALUE_W-1:0] value);
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.position  <= pos;
    req_ch.value     <= value;
    req_held = 1'b1;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.note_request(op, pos, value);
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      req_ch.valid <= 1'b0;
      req_held = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      // Every so often run a long burst with no idle cycles at all.
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 12);
    end
  endtask

  // Pick a value word: mostly random, with the all-zero and all-one words mixed in.
  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // Build one random request. Inserts and deletes at a position mostly use a
  // position that is valid for the current length; the rest land just outside
  // or far out of range.
  function automatic void pick_request(input drift_t drift, output logic [OP_W-1:0] op,
                                       output logic [POS_W-1:0] pos,
                                       output logic [VALUE_W-1:0] value);
    int unsigned n, r, ins_pct, limit;
    n = sb.length();
    case (drift)
      DRIFT_GROW:   ins_pct = 75;
      DRIFT_SHRINK: ins_pct = 20;
      default:      ins_pct = 45;
    endcase
    r = $urandom_range(0, 99);
    if (r < ins_pct) begin
      case ($urandom_range(0, 2))
        0:       op = OP_INS_FRONT;
        1:       op = OP_INS_BACK;
        default: op = OP_INS_POS;
      endcase
    end else if (r < 91) begin
      case ($urandom_range(0, 2))
        0:       op = OP_DEL_FRONT;
        1:       op = OP_DEL_BACK;
        default: op = OP_DEL_POS;
      endcase
    end else if (r < 98) begin
      op = OP_READOUT;
    end else begin
      op = OP_UNUSED;
    end

    pos   = POS_W'($urandom_range(0, 63));
    value = pick_value();
    if (op == OP_INS_POS || op == OP_DEL_POS) begin
      limit = (op == OP_INS_POS) ? n + 1 : n;
      if (limit >= 1 && $urandom_range(0, 9) < 8) begin
        pos = POS_W'($urandom_range(1, limit));
      end else if ($urandom_range(0, 1) == 0) begin
        pos = '0;
      end else begin
        pos = POS_W'($urandom_range(limit + 1, 63));
      end
    end
  endfunction

  // Result side: check every transfer and stall according to a segment
  // pattern. The sixth segment holds ready low for a long stretch so the
  // request side backs up.
  initial begin
    int unsigned seg_left, seg_index, phase;
    rx_mode_t    mode;
    logic        take;
    seg_left  = 0;
    seg_index = 0;
    phase     = 0;
    mode      = RX_OPEN;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        sb.check_result(rsp_ch.element, rsp_ch.last_of_run, rsp_ch.status, rsp_ch.count);
      end
      if (seg_left == 0) begin
        seg_index++;
        if (seg_index == 6) begin
          mode     = RX_HOLD;
          seg_left = LONG_HOLD;
        end else begin
          case ($urandom_range(0, 2))
            0:       mode = RX_OPEN;
            1:       mode = RX_RANDOM;
            default: mode = RX_PATTERN;
          endcase
          seg_left = $urandom_range(20, 120);
        end
      end
      seg_left--;
      phase++;
      case (mode)
        RX_OPEN:    take = 1'b1;
        RX_RANDOM:  take = ($urandom_range(0, 2) != 0);
        RX_PATTERN: take = ((phase % 5) < 2);
        default:    take = 1'b0;
      endcase
      rsp_ch.ready <= take;
    end
  end

  // Request side: reset, directed requests, random requests, then drain.
  initial begin
    logic [OP_W-1:0]    op;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] value;
    drift_t             drift;
    int unsigned        drift_left;

    req_ch.valid     <= 1'b0;
    req_ch.operation <= OP_INS_FRONT;
    req_ch.position  <= '0;
    req_ch.value     <= '0;
    rst              <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Empty list: readout gives a single empty result, every delete is ignored.
    send_request(OP_READOUT,   6'd0,  32'h0000_0000);
    send_request(OP_DEL_FRONT, 6'd0,  32'h0000_0000);
    send_request(OP_DEL_BACK,  6'd1,  32'h1234_5678);
    send_request(OP_DEL_POS,   6'd63, 32'hFFFF_FFFF);
    // Insert positions out of range on an empty list.
    send_request(OP_INS_POS,   6'd0,  32'hDEAD_BEEF);
    send_request(OP_INS_POS,   6'd2,  32'hDEAD_BEEF);
    // Build a short list through every insert kind, with extreme words.
    send_request(OP_INS_POS,   6'd1,  32'hFFFF_FFFF);
    send_request(OP_INS_FRONT, 6'd63, 32'h0000_0000);
    send_request(OP_INS_BACK,  6'd0,  32'hA5A5_5A5A);
    send_request(OP_INS_POS,   6'd63, 32'h5555_AAAA);
    send_request(OP_INS_POS,   6'd4,  32'h0000_0001);
    send_request(OP_INS_POS,   6'd2,  32'h8000_0000);
    send_request(OP_READOUT,   6'd63, 32'hFFFF_FFFF);
    // Delete positions just outside the range, then the last and a middle word.
    send_request(OP_DEL_POS,   6'd0,  32'h0000_0000);
    send_request(OP_DEL_POS,   6'd6,  32'h0000_0000);
    send_request(OP_DEL_POS,   6'd5,  32'h0000_0000);
    send_request(OP_DEL_POS,   6'd2,  32'h0000_0000);
    // Unused operation code with every other field at all ones.
    send_request(OP_UNUSED,    6'd63, 32'hFFFF_FFFF);
    send_request(OP_DEL_FRONT, 6'd0,  32'h0000_0000);
    send_request(OP_DEL_BACK,  6'd0,  32'h0000_0000);
    send_request(OP_READOUT,   6'd0,  32'h0000_0000);
    send_request(OP_DEL_FRONT, 6'd0,  32'h0000_0000);
    send_request(OP_READOUT,   6'd0,  32'h0000_0000);

    // Random part. Start with a long growth phase so the list fills and
    // inserts get refused, then wander between growing, shrinking and mixing.
    drift      = DRIFT_GROW;
    drift_left = 70;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (drift_left == 0) begin
        case ($urandom_range(0, 2))
          0:       drift = DRIFT_GROW;
          1:       drift = DRIFT_SHRINK;
          default: drift = DRIFT_MIX;
        endcase
        drift_left = $urandom_range(30, 70);
      end
      drift_left--;
      pick_request(drift, op, pos, value);
      send_request(op, pos, value);
    end

    // Drop valid if the last burst left it high, in this same step.
    if (req_held) begin
      req_ch.valid <= 1'b0;
      req_held = 1'b0;
    end

    // Wait for every expected result, then watch a while for stray ones.
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("positional_ordered_list regression: pass");
    end else begin
      $display("positional_ordered_list regression: fail");
    end
    $finish;
  end

endmodule
